### rtl/rsv_pkg.sv
`timescale 1ns / 1ps

package rsv_pkg;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_SHORT   = 3'd1,
        ST_ACKLIKE = 3'd2,
        ST_YEAR    = 3'd3,
        ST_MONTH   = 3'd4,
        ST_TIME    = 3'd5,
        ST_DAY     = 3'd6
    } t_status;

    localparam logic [15:0] MIN_LEN     = 16'd7;
    localparam logic [15:0] ACK_LEN     = 16'd19;
    localparam logic [15:0] SUN_LEN     = 16'd15;
    localparam logic [7:0]  ACK_MARK    = 8'h2B;
    localparam logic [15:0] YEAR_LO     = 16'd2000;
    localparam logic [15:0] YEAR_HI     = 16'd2099;
    localparam logic [15:0] MIN_PER_DAY = 16'd1440;

    // y + y/4 - y/100 + y/400 reduced mod 7 for y = 1999
    localparam logic [7:0]  Y1999_TERM  = 8'd5;

    typedef struct packed {
        logic [15:0] payload_len;
        logic [15:0] year_field;
        logic [7:0]  month_field;
        logic [7:0]  day_field;
        logic [7:0]  hour_field;
        logic [7:0]  minute_field;
        logic [7:0]  second_field;
        logic [15:0] sunrise_field;
        logic [15:0] sunset_field;
        logic [15:0] dawn_field;
        logic [15:0] dusk_field;
    } t_in;

    typedef struct packed {
        t_status     status;
        logic [2:0]  weekday;
        logic [6:0]  year_offset;
        logic        sun_valid;
    } t_out;

    // Sakamoto month offsets, months 1..12
    function automatic logic [2:0] month_key(input logic [7:0] month);
        logic [2:0] k;
        case (month)
            8'd1:    k = 3'd0;
            8'd2:    k = 3'd3;
            8'd3:    k = 3'd2;
            8'd4:    k = 3'd5;
            8'd5:    k = 3'd0;
            8'd6:    k = 3'd3;
            8'd7:    k = 3'd5;
            8'd8:    k = 3'd1;
            8'd9:    k = 3'd4;
            8'd10:   k = 3'd6;
            8'd11:   k = 3'd2;
            8'd12:   k = 3'd4;
            default: k = 3'd0;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] days_in_month(input logic [7:0] month,
                                                 input logic       leap);
        logic [4:0] d;
        case (month)
            8'd2:                      d = leap ? 5'd29 : 5'd28;
            8'd4, 8'd6, 8'd9, 8'd11:   d = 5'd30;
            default:                   d = 5'd31;
        endcase
        return d;
    endfunction

    // x mod 7 for 9-bit x: reciprocal estimate never overshoots, one fixup
    function automatic logic [2:0] mod7(input logic [8:0] x);
        logic [15:0] p;
        logic [6:0]  q;
        logic [8:0]  r;
        p = {7'd0, x} * 16'd73;
        q = p[15:9];
        r = x - 9'({2'd0, q} * 9'd7);
        if (r >= 9'd7) begin
            r = r - 9'd7;
        end
        return r[2:0];
    endfunction

endpackage

### rtl/rtc_set_payload_validator.sv
`timescale 1ns / 1ps
// Time-set message checker.
// Input channel: i_in_valid / o_in_ready carry one request of pre-parsed
// message fields (i_in_data). Output channel: o_out_valid / i_out_ready carry
// one result (o_out_data): status code, weekday (Mon=1..Sun=7), year offset
// from 2000 and the sun-time valid flag. Failed checks zero the last three.
// The request is registered at the accepting edge, checked in one pass of
// combinational logic, and loaded into the result register when the output
// slot is empty or being taken. Throughput: one request per cycle, set by
// the two-deep register pipeline; both stages advance together whenever
// the output slot is empty or being taken.
// When the receiver stalls, the result register holds and the input register
// fills; o_in_ready drops only when both are occupied.
// Reset (synchronous, active low) empties both stages; only the pipeline
// valid bits are reset, not the data registers.
module rtc_set_payload_validator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  rsv_pkg::t_in       i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output rsv_pkg::t_out      o_out_data
);

    logic          r_s1_vld;
    rsv_pkg::t_in  r_s1;
    logic          r_out_vld;
    rsv_pkg::t_out r_out;
    rsv_pkg::t_out n_out;

    logic s2_rdy;
    logic s1_rdy;

    assign s2_rdy     = !r_out_vld || i_out_ready;
    assign s1_rdy     = !r_s1_vld || s2_rdy;
    assign o_in_ready = s1_rdy;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (s1_rdy) begin
                r_s1_vld <= i_in_valid;
            end
            if (s2_rdy) begin
                r_out_vld <= r_s1_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_rdy && i_in_valid) begin
            r_s1 <= i_in_data;
        end
        if (s2_rdy && r_s1_vld) begin
            r_out <= n_out;
        end
    end

    // check logic
    logic [15:0]      year_diff;
    logic [6:0]       yoff;
    logic             early;
    logic [6:0]       k;
    logic [7:0]       yterm;
    logic [8:0]       dsum;
    logic [2:0]       dow;
    logic             time_bad;
    logic             sun_ok;
    rsv_pkg::t_status st;

    always_comb begin
        year_diff = r_s1.year_field - rsv_pkg::YEAR_LO;
        yoff      = year_diff[6:0];
        early     = (r_s1.month_field < 8'd3);
        k         = yoff - {6'd0, early};
        // Jan/Feb of 2000 fall back into 1999, outside the k-based formula
        if (early && (yoff == 7'd0)) begin
            yterm = rsv_pkg::Y1999_TERM;
        end else begin
            yterm = {1'b0, k} + {3'd0, k[6:2]};
        end
        dsum = {1'b0, yterm} + {6'd0, rsv_pkg::month_key(r_s1.month_field)}
               + {1'b0, r_s1.day_field};
        dow  = rsv_pkg::mod7(dsum);

        time_bad = (r_s1.hour_field > 8'd23) || (r_s1.minute_field > 8'd59)
                   || (r_s1.second_field > 8'd59);

        if (r_s1.payload_len < rsv_pkg::MIN_LEN) begin
            st = rsv_pkg::ST_SHORT;
        end else if ((r_s1.payload_len >= rsv_pkg::ACK_LEN)
                     && (r_s1.year_field[15:8] == rsv_pkg::ACK_MARK)) begin
            st = rsv_pkg::ST_ACKLIKE;
        end else if ((r_s1.year_field < rsv_pkg::YEAR_LO)
                     || (r_s1.year_field > rsv_pkg::YEAR_HI)) begin
            st = rsv_pkg::ST_YEAR;
        end else if ((r_s1.month_field < 8'd1) || (r_s1.month_field > 8'd12)) begin
            st = rsv_pkg::ST_MONTH;
        end else if (time_bad) begin
            st = rsv_pkg::ST_TIME;
        end else if ((r_s1.day_field < 8'd1)
                     || (r_s1.day_field > {3'd0, rsv_pkg::days_in_month(
                            r_s1.month_field, (r_s1.year_field[1:0] == 2'd0))})) begin
            st = rsv_pkg::ST_DAY;
        end else begin
            st = rsv_pkg::ST_OK;
        end

        sun_ok = (r_s1.payload_len >= rsv_pkg::SUN_LEN)
                 && (r_s1.sunrise_field < rsv_pkg::MIN_PER_DAY)
                 && (r_s1.sunset_field < rsv_pkg::MIN_PER_DAY)
                 && (r_s1.dawn_field < rsv_pkg::MIN_PER_DAY)
                 && (r_s1.dusk_field < rsv_pkg::MIN_PER_DAY);

        n_out.status = st;
        if (st == rsv_pkg::ST_OK) begin
            n_out.weekday     = (dow == 3'd0) ? 3'd7 : dow;
            n_out.year_offset = yoff;
            n_out.sun_valid   = sun_ok;
        end else begin
            n_out.weekday     = 3'd0;
            n_out.year_offset = 7'd0;
            n_out.sun_valid   = 1'b0;
        end
    end

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status != rsv_pkg::ST_OK))
        |-> ((o_out_data.weekday == 3'd0) && (o_out_data.year_offset == 7'd0)
             && !o_out_data.sun_valid))
        else $error("failed check left nonzero result fields");

    a_ok_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status == rsv_pkg::ST_OK))
        |-> ((o_out_data.weekday != 3'd0) && (o_out_data.year_offset <= 7'd99)))
        else $error("ok result with weekday or year offset out of range");

    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_in_ready) |-> (o_out_valid && !i_out_ready))
        else $error("input stalled while output slot free");

endmodule
